// ===== rtl/core/tte_pkg.sv =====
package tte_pkg;

  localparam int RING_DEPTH = 8;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int DATA_W     = 16;
  localparam int SUM_W      = DATA_W + $clog2(RING_DEPTH);

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int NUM_W   = MUL_A_W + MUL_B_W;

  localparam int FPS_W   = 14;
  localparam int FPS_TOP = FPS_W - 1;
  // 50.0 and 12.5 fps in q6.8
  localparam logic [FPS_W-1:0] FPS_HIGH = 14'd12800;
  localparam logic [FPS_W-1:0] FPS_LOW  = 14'd3200;

  // multiply by 4 and scale to q8.8 gives 2^10
  localparam int QSCALE_LOG2 = 10;
  localparam int SHIFT_W     = 7;
  localparam logic [SHIFT_W-1:0] SHIFT_INIT = SHIFT_W'(QSCALE_LOG2 - NUM_W);

  localparam int STEP_W = $clog2(SUM_W + 2);

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 4'd1;

  localparam logic [DATA_W-1:0] TICK_RATE_RST = 16'd1000;
  localparam logic [DATA_W-1:0] TIMEOUT_RST   = 16'd2000;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_TAP   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic RES_TAP   = 1'b0;
  localparam logic RES_QUERY = 1'b1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] clip_span;
    logic [DATA_W-1:0] clip_frames;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [DATA_W-1:0] tempo_ticks;
    logic              new_sequence;
    logic [FPS_W-1:0]  fps_value;
    logic              fps_valid;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic sweep;
  } ring_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] quot;
    logic              rem_nz;
  } div_stat_t;

endpackage

// ===== rtl/core/tte_ring.sv =====
module tte_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  tte_pkg::ring_ctl_t            ctl,
  input  logic [tte_pkg::DATA_W-1:0]    wdata,
  output logic [tte_pkg::SUM_W-1:0]     sum,
  output logic [tte_pkg::CNT_W-1:0]     count,
  output logic                          last
);
  import tte_pkg::*;

  logic [DATA_W-1:0] ring [RING_DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [SLOT_W-1:0] idx;

  assign slot_next = (slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
  assign last      = (idx == SLOT_W'(RING_DEPTH - 1));

  // one entry a cycle into the running sum of nonzero intervals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
      slot  <= '0;
      idx   <= '0;
      sum   <= '0;
      count <= '0;
    end else if (ctl.clear) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else if (ctl.push) begin
      ring[slot_next] <= wdata;
      slot            <= slot_next;
      idx             <= '0;
      sum             <= '0;
      count           <= '0;
    end else if (ctl.sweep) begin
      if (ring[idx] != '0) begin
        sum   <= sum + SUM_W'(ring[idx]);
        count <= count + 1'b1;
      end
      idx <= last ? '0 : idx + 1'b1;
    end
  end

endmodule

// ===== rtl/core/tte_mul.sv =====
module tte_mul (
  input  logic                          clk,
  input  tte_pkg::unit_ctl_t            ctl,
  input  logic [tte_pkg::MUL_A_W-1:0]   a,
  input  logic [tte_pkg::MUL_B_W-1:0]   b,
  output logic [tte_pkg::NUM_W-1:0]     product
);
  import tte_pkg::*;

  logic [MUL_A_W-1:0] mcand;
  logic [MUL_A_W-1:0] acc_hi;
  logic [MUL_B_W-1:0] acc_lo;
  logic [MUL_A_W:0]   psum;

  // shift-add, one multiplier bit a cycle, low product bits replace it
  assign psum    = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mcand} : '0);
  assign product = {acc_hi, acc_lo};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand  <= a;
      acc_hi <= '0;
      acc_lo <= b;
    end else if (ctl.step) begin
      acc_hi <= psum[MUL_A_W:1];
      acc_lo <= {psum[0], acc_lo[MUL_B_W-1:1]};
    end
  end

endmodule

// ===== rtl/core/tte_div.sv =====
module tte_div (
  input  logic                          clk,
  input  tte_pkg::unit_ctl_t            ctl,
  input  logic [tte_pkg::NUM_W-1:0]     dividend,
  input  logic [tte_pkg::DATA_W-1:0]    divisor,
  output tte_pkg::div_stat_t            stat
);
  import tte_pkg::*;

  logic [NUM_W-1:0]  dvd;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quot;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              qbit;

  // restoring division, one quotient bit a cycle, zeros shift in past the end
  assign trial = {rem, dvd[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  assign stat.quot   = quot;
  assign stat.rem_nz = (|rem) | (|dvd);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (ctl.step) begin
      rem  <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dvd  <= {dvd[NUM_W-2:0], 1'b0};
      quot <= {quot[DATA_W-2:0], qbit};
    end
  end

endmodule

// ===== rtl/core/tap_tempo_estimator_top.sv =====
// tick: taken without leaving idle, no result; tap: result after a ring sweep and
//   a serial divide (divide skipped with an empty ring), with neither on timeout
// query: two serial multiplies, then one quotient bit a cycle until the leading
//   14 bits are found; neither when tempo or product is zero
// one item in flight; a new word is taken while the previous result waits
// synchronous reset restores register defaults, elapsed count saturated, ring zero
module tap_tempo_estimator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  tte_pkg::in_item_t               item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output tte_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tte_pkg::DATA_W-1:0]      cfg_data
);
  import tte_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SWEEP = 7'b0000010,
    ST_TDIV  = 7'b0000100,
    ST_MUL1  = 7'b0001000,
    ST_MUL2  = 7'b0010000,
    ST_QDIV  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t             state;
  logic [DATA_W-1:0]  tick_rate;
  logic [DATA_W-1:0]  timeout_ticks;
  logic [DATA_W-1:0]  elapsed;
  logic [DATA_W-1:0]  beat;
  logic [STEP_W-1:0]  step_cnt;
  logic [SHIFT_W-1:0] shift;
  out_item_t          pend;

  logic               accept;
  logic               emit_go;
  logic               timed_out;
  logic               q_invalid;
  ring_ctl_t          ring_ctl;
  unit_ctl_t          mul_ctl;
  unit_ctl_t          div_ctl;
  logic [SUM_W-1:0]   ring_sum;
  logic [CNT_W-1:0]   ring_count;
  logic               ring_last;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [NUM_W-1:0]   mul_product;
  logic [NUM_W-1:0]   div_dvd;
  logic [DATA_W-1:0]  div_dvs;
  div_stat_t          div_stat;
  logic [FPS_W-1:0]   zf;
  logic [FPS_W-1:0]   fps_fold;

  assign item_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid & item_ready;
  assign emit_go    = (state == ST_EMIT) && (!result_valid || result_ready);
  assign timed_out  = (elapsed > timeout_ticks);
  assign q_invalid  = (beat == '0) || (item.clip_span == '0) ||
                      (item.clip_frames == '0) || (tick_rate == '0);

  tte_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ring_ctl),
    .wdata (elapsed),
    .sum   (ring_sum),
    .count (ring_count),
    .last  (ring_last)
  );

  tte_mul u_mul (
    .clk     (clk),
    .ctl     (mul_ctl),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_product)
  );

  tte_div u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat)
  );

  always_comb begin
    ring_ctl = '0;
    mul_ctl  = '0;
    div_ctl  = '0;
    mul_a    = MUL_A_W'(item.clip_span);
    mul_b    = item.clip_frames;
    div_dvd  = {ring_sum, {(NUM_W - SUM_W){1'b0}}};
    div_dvs  = DATA_W'(ring_count);
    unique case (state)
      ST_IDLE: begin
        if (accept && item.kind == KIND_TAP) begin
          ring_ctl.clear = timed_out;
          ring_ctl.push  = !timed_out;
        end
        mul_ctl.load = accept && (item.kind == KIND_QUERY) && !q_invalid;
      end
      ST_SWEEP: begin
        ring_ctl.sweep = 1'b1;
      end
      ST_TDIV: begin
        div_ctl.load = (step_cnt == '0);
        div_ctl.step = (step_cnt != '0);
      end
      ST_MUL1: begin
        mul_a        = mul_product[MUL_A_W-1:0];
        mul_b        = tick_rate;
        mul_ctl.load = (step_cnt == STEP_W'(MUL_B_W));
        mul_ctl.step = (step_cnt != STEP_W'(MUL_B_W));
      end
      ST_MUL2: begin
        div_dvd      = mul_product;
        div_dvs      = beat;
        div_ctl.load = (step_cnt == STEP_W'(MUL_B_W));
        mul_ctl.step = (step_cnt != STEP_W'(MUL_B_W));
      end
      ST_QDIV: begin
        div_ctl.step = !div_stat.quot[FPS_TOP];
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // quotient has its leading one at the top of the 14-bit window; shift tells
  // how far that window sits from the unfolded q8.8 value
  assign zf = div_stat.quot[FPS_W-1:0];

  always_comb begin
    priority if (shift[SHIFT_W-1] || shift == '0) begin
      fps_fold = (zf > FPS_HIGH || (zf == FPS_HIGH && div_stat.rem_nz)) ? zf >> 1 : zf;
    end else if (shift == SHIFT_W'(1)) begin
      fps_fold = zf >> 1;
    end else begin
      fps_fold = (zf < FPS_HIGH) ? zf >> 1 : zf >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tick_rate     <= TICK_RATE_RST;
      timeout_ticks <= TIMEOUT_RST;
      elapsed       <= '1;
      beat          <= '0;
      step_cnt      <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TICK_RATE: tick_rate     <= cfg_data;
          REG_TIMEOUT:   timeout_ticks <= cfg_data;
          default: begin
          end
        endcase
      end

      if (emit_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.kind)
              KIND_TICK: begin
                if (elapsed != '1) begin
                  elapsed <= elapsed + 1'b1;
                end
              end
              KIND_TAP: begin
                elapsed           <= '0;
                pend.result_kind  <= RES_TAP;
                pend.tempo_ticks  <= beat;
                pend.new_sequence <= timed_out;
                pend.fps_value    <= '0;
                pend.fps_valid    <= 1'b0;
                state             <= timed_out ? ST_EMIT : ST_SWEEP;
              end
              KIND_QUERY: begin
                pend.result_kind  <= RES_QUERY;
                pend.tempo_ticks  <= beat;
                pend.new_sequence <= 1'b0;
                pend.fps_value    <= '0;
                pend.fps_valid    <= 1'b0;
                step_cnt          <= '0;
                state             <= q_invalid ? ST_EMIT : ST_MUL1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (ring_last) begin
            step_cnt <= '0;
            state    <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == '0 && ring_count == '0) begin
            beat             <= '0;
            pend.tempo_ticks <= '0;
            state            <= ST_EMIT;
          end else if (step_cnt == STEP_W'(SUM_W + 1)) begin
            beat             <= div_stat.quot;
            pend.tempo_ticks <= div_stat.quot;
            state            <= ST_EMIT;
          end
        end
        ST_MUL1: begin
          if (step_cnt == STEP_W'(MUL_B_W)) begin
            step_cnt <= '0;
            state    <= ST_MUL2;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        ST_MUL2: begin
          if (step_cnt == STEP_W'(MUL_B_W)) begin
            step_cnt <= '0;
            shift    <= SHIFT_INIT;
            state    <= ST_QDIV;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        ST_QDIV: begin
          if (div_stat.quot[FPS_TOP]) begin
            pend.fps_value <= fps_fold;
            pend.fps_valid <= 1'b1;
            state          <= ST_EMIT;
          end else begin
            shift <= shift + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            result <= pend;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tte_checker.sv =====
module tte_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            result_valid,
  input logic                            result_ready,
  input tte_pkg::out_item_t              result
);
  import tte_pkg::*;

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  // folded speed always lands between 12.5 and 50 fps
  a_fps_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.fps_valid |->
      result.fps_value >= FPS_LOW && result.fps_value <= FPS_HIGH)
    else $error("fps outside folding range");

  a_tap_no_fps: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RES_TAP |->
      !result.fps_valid && result.fps_value == '0)
    else $error("tap answer carries a speed");

  a_query_no_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RES_QUERY |-> !result.new_sequence)
    else $error("query answer flags a new sequence");

endmodule

bind tap_tempo_estimator_top tte_checker u_tte_checker (.*);
